/* rtl/core/mshash_pkg.sv */
// Package for the mid-square chained hash table: sizes, status codes,
// state encoding and the decimal power table. No dependencies.
`default_nettype none
package mshash_pkg;
	localparam int BucketCount = 128;
	localparam int ChainDepth = 8;
	localparam int BucketW = 7;
	localparam int PosW = 3;
	localparam int FillW = 4;
	localparam int SlotW = BucketW + PosW;
	localparam int KeyW = 31;
	localparam int PayW = 32;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_SHORT     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ_LO, S_SQ_HI, S_LEN, S_DIG, S_RD, S_FILL, S_WALK, S_CMP, S_OUT
	} state_t;

	// 10**n, n = 0..19
	function automatic logic [63:0] dec_pow(input logic [4:0] n);
		logic [63:0] p;
		unique case (n)
			5'd0:  p = 64'd1;
			5'd1:  p = 64'd10;
			5'd2:  p = 64'd100;
			5'd3:  p = 64'd1000;
			5'd4:  p = 64'd10000;
			5'd5:  p = 64'd100000;
			5'd6:  p = 64'd1000000;
			5'd7:  p = 64'd10000000;
			5'd8:  p = 64'd100000000;
			5'd9:  p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			5'd18: p = 64'd1000000000000000000;
			5'd19: p = 64'd10000000000000000000;
			default: p = 64'd0;
		endcase
		return p;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/mshash_store.sv */
// Chain store: key and payload memories with registered read, plus the
// bucket fill memory. Uses mshash_pkg.
`default_nettype none
module mshash_store (
	input  wire logic                           clk,
	input  wire logic [mshash_pkg::SlotW-1:0]   slot_addr,
	input  wire logic                           slot_we,
	input  wire logic [mshash_pkg::KeyW-1:0]    wkey,
	input  wire logic [mshash_pkg::PayW-1:0]    wpay,
	output logic      [mshash_pkg::KeyW-1:0]    rkey,
	output logic      [mshash_pkg::PayW-1:0]    rpay,
	input  wire logic [mshash_pkg::BucketW-1:0] fill_addr,
	input  wire logic                           fill_we,
	input  wire logic [mshash_pkg::FillW-1:0]   wfill,
	output logic      [mshash_pkg::FillW-1:0]   rfill
);
	logic [mshash_pkg::KeyW-1:0] key_mem [mshash_pkg::BucketCount*mshash_pkg::ChainDepth];
	logic [mshash_pkg::PayW-1:0] pay_mem [mshash_pkg::BucketCount*mshash_pkg::ChainDepth];
	logic [mshash_pkg::FillW-1:0] fill_mem [mshash_pkg::BucketCount];

	always_ff @(posedge clk) begin
		if (slot_we) begin
			key_mem[slot_addr] <= wkey;
			pay_mem[slot_addr] <= wpay;
		end
		rkey <= key_mem[slot_addr];
		rpay <= pay_mem[slot_addr];
		if (fill_we) fill_mem[fill_addr] <= wfill;
		rfill <= fill_mem[fill_addr];
	end
endmodule
`default_nettype wire

/* rtl/core/mid_square_chained_hash_table.sv */
// Mid-square hash table with fixed-depth chains, top level.
// Steps from the accepting edge to m_tvalid: square (low and high halves),
// digit count, one step per decimal digit up to the hash window (digits 7 to 9
// from the top), fill read, then insert if there is room, and output; search
// walks the chain entry by entry until a match; a short square goes straight to output.
// Reset: the bucket fill memory is swept to zero bucket by bucket; no item is taken until then.
`default_nettype none
module mid_square_chained_hash_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [0] action, [31:1] student_key, [63:32] record_payload
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [2:0] status, [9:3] bucket_index, [13:10] chain_position,
	// [45:14] found_payload, [49:46] probe_count, rest zero
	output logic [55:0]      m_tdata
);
	mshash_pkg::state_t state_q, state_d;
	logic        clr_q;
	logic [mshash_pkg::BucketW-1:0] clr_cnt_q;
	logic        act_q;
	logic [mshash_pkg::KeyW-1:0] key_q;
	logic [mshash_pkg::PayW-1:0] pay_q;
	logic [63:0] sq_q, rem_q, dpow_q;
	logic [46:0] plo_q;
	logic [4:0]  end_q, pidx_q;
	logic [3:0]  top_q;
	logic [9:0]  mid_q;
	logic [mshash_pkg::BucketW-1:0] bkt_q;
	logic [mshash_pkg::FillW-1:0]   fill_q, idx_q;
	logic [2:0]  ost_q;
	logic [3:0]  opos_q, oprb_q;
	logic [31:0] ofnd_q;
	logic [49:0] out_q;
	logic        ovld_q;

	logic [mshash_pkg::SlotW-1:0] slot_addr;
	logic slot_we, fill_we;
	logic [mshash_pkg::BucketW-1:0] fill_addr;
	logic [mshash_pkg::FillW-1:0] wfill, rfill;
	logic [mshash_pkg::KeyW-1:0] rkey;
	logic [mshash_pkg::PayW-1:0] rpay;
	logic [4:0] ncnt, endv;
	logic [63:0] dmul [10];
	logic [64:0] diff;
	logic [63:0] rem_d;
	logic [3:0]  digit;
	logic [9:0]  mid_d;
	logic        out_go;

	mshash_store u_store (
		.clk(clk), .slot_addr(slot_addr), .slot_we(slot_we), .wkey(key_q), .wpay(pay_q),
		.rkey(rkey), .rpay(rpay), .fill_addr(fill_addr), .fill_we(fill_we),
		.wfill(wfill), .rfill(rfill)
	);

	// Decimal digit count of the square.
	always_comb begin
		ncnt = 5'd1;
		for (int i = 1; i < 20; i++)
			if (sq_q >= mshash_pkg::dec_pow(5'(i))) ncnt = 5'(i + 1);
		endv = (ncnt < 5'd9) ? ncnt : 5'd9;
	end

	// Peel one decimal digit off the top: largest multiple of the digit weight that fits.
	always_comb begin
		dmul[0] = '0;
		dmul[1] = dpow_q;
		dmul[2] = {dpow_q[62:0], 1'b0};
		dmul[3] = {dpow_q[62:0], 1'b0} + dpow_q;
		dmul[4] = {dpow_q[61:0], 2'b0};
		dmul[5] = {dpow_q[61:0], 2'b0} + dpow_q;
		dmul[6] = {dpow_q[61:0], 2'b0} + {dpow_q[62:0], 1'b0};
		dmul[7] = {dpow_q[60:0], 3'b0} - dpow_q;
		dmul[8] = {dpow_q[60:0], 3'b0};
		dmul[9] = {dpow_q[60:0], 3'b0} + dpow_q;
		digit = '0;
		rem_d = rem_q;
		diff = '0;
		for (int k = 1; k < 10; k++) begin
			diff = {1'b0, rem_q} - {1'b0, dmul[k]};
			if (!diff[64]) begin
				digit = 4'(k);
				rem_d = diff[63:0];
			end
		end
		mid_d = (top_q >= 4'd6) ?
			{mid_q[6:0], 3'b0} + {mid_q[8:0], 1'b0} + {6'd0, digit} : mid_q;
	end

	assign s_tready = (state_q == mshash_pkg::S_IDLE) && !clr_q;
	assign m_tvalid = ovld_q;
	assign m_tdata = {6'd0, out_q};

	always_comb begin
		state_d = state_q;
		slot_addr = {bkt_q, idx_q[2:0]};
		slot_we = 1'b0;
		fill_addr = clr_q ? clr_cnt_q : bkt_q;
		fill_we = clr_q;
		wfill = '0;
		out_go = 1'b0;
		unique case (state_q)
			mshash_pkg::S_IDLE: if (s_tready && s_tvalid) state_d = mshash_pkg::S_SQ_LO;
			mshash_pkg::S_SQ_LO: state_d = mshash_pkg::S_SQ_HI;
			mshash_pkg::S_SQ_HI: state_d = mshash_pkg::S_LEN;
			mshash_pkg::S_LEN: state_d = (ncnt < 5'd7) ? mshash_pkg::S_OUT : mshash_pkg::S_DIG;
			mshash_pkg::S_DIG: if (({1'b0, top_q} + 5'd1) == end_q) state_d = mshash_pkg::S_RD;
			mshash_pkg::S_RD: state_d = mshash_pkg::S_FILL;
			mshash_pkg::S_FILL: begin
				if (act_q) state_d = mshash_pkg::S_WALK;
				else begin
					state_d = mshash_pkg::S_OUT;
					if (rfill < 4'(mshash_pkg::ChainDepth)) begin
						slot_addr = {bkt_q, rfill[2:0]};
						slot_we = 1'b1;
						fill_we = 1'b1;
						wfill = rfill + 4'd1;
					end
				end
			end
			mshash_pkg::S_WALK: state_d = (idx_q >= fill_q) ? mshash_pkg::S_OUT : mshash_pkg::S_CMP;
			mshash_pkg::S_CMP: state_d = (rkey == key_q) ? mshash_pkg::S_OUT : mshash_pkg::S_WALK;
			mshash_pkg::S_OUT: begin
				// hold until the output register is free
				if (!ovld_q || m_tready) begin
					out_go = 1'b1;
					state_d = mshash_pkg::S_IDLE;
				end
			end
			default: state_d = mshash_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mshash_pkg::S_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 7'd1;
				if (clr_cnt_q == 7'd127) clr_q <= 1'b0;
			end
			ovld_q <= out_go || (ovld_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mshash_pkg::S_IDLE: begin
				act_q <= s_tdata[0];
				key_q <= s_tdata[31:1];
				pay_q <= s_tdata[63:32];
			end
			mshash_pkg::S_SQ_LO:
				// 31x31 square split into a 16x31 and a 15x31 product
				plo_q <= {31'd0, key_q[15:0]} * {16'd0, key_q};
			mshash_pkg::S_SQ_HI:
				sq_q <= {17'd0, plo_q} +
					{2'd0, ({31'd0, key_q[30:16]} * {15'd0, key_q}), 16'd0};
			mshash_pkg::S_LEN: begin
				end_q <= endv;
				pidx_q <= ncnt - 5'd1;
				dpow_q <= mshash_pkg::dec_pow(ncnt - 5'd1);
				rem_q <= sq_q;
				top_q <= '0;
				mid_q <= '0;
				ost_q <= 3'(mshash_pkg::ST_SHORT);
				opos_q <= '0; ofnd_q <= '0; oprb_q <= '0;
				bkt_q <= '0;
			end
			mshash_pkg::S_DIG: begin
				rem_q <= rem_d;
				mid_q <= mid_d;
				top_q <= top_q + 4'd1;
				pidx_q <= pidx_q - 5'd1;
				dpow_q <= mshash_pkg::dec_pow(pidx_q - 5'd1);
				// bucket count is a power of two: keep the low bits
				bkt_q <= mid_d[mshash_pkg::BucketW-1:0];
			end
			mshash_pkg::S_FILL: begin
				fill_q <= rfill;
				idx_q <= '0;
				opos_q <= rfill;
				if (!act_q) ost_q <= (rfill < 4'(mshash_pkg::ChainDepth)) ?
					3'(mshash_pkg::ST_INSERTED) : 3'(mshash_pkg::ST_FULL);
				else begin
					ost_q <= 3'(mshash_pkg::ST_NOT_FOUND);
					opos_q <= '0;
					oprb_q <= rfill + 4'd3;
				end
			end
			mshash_pkg::S_CMP: begin
				if (rkey == key_q) begin
					ost_q <= 3'(mshash_pkg::ST_FOUND);
					opos_q <= idx_q;
					ofnd_q <= rpay;
					oprb_q <= idx_q + 4'd3;
				end
				idx_q <= idx_q + 4'd1;
			end
			default: ;
		endcase
		if (out_go) out_q <= {oprb_q, ofnd_q, opos_q, bkt_q, ost_q};
	end

	a_out_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mshash_pkg::S_OUT) |=> ovld_q) else $error("result not raised");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_tready) else $error("accept during clear");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mshash_pkg::S_CMP) |-> (idx_q < fill_q)) else $error("walk past fill");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while waiting");
endmodule
`default_nettype wire

/* tb/mshash_checker.sv */
// Checker for the mid-square chained hash table: watches both item channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on mshash_pkg.
`default_nettype none
module mshash_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	output int               fail_count,
	output int               pending_count,
	output int               result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  probes;
		logic [31:0] payload;
		logic [3:0]  pos;
		logic [6:0]  bucket;
		logic [2:0]  status;
	} table_result_t;

	table_result_t expected_results[$];
	logic [3:0]  fill_of[mshash_pkg::BucketCount];
	logic [30:0] key_of[mshash_pkg::BucketCount*mshash_pkg::ChainDepth];
	logic [31:0] pay_of[mshash_pkg::BucketCount*mshash_pkg::ChainDepth];

	// Mid-square bucket; returns 0 when the square has fewer than seven digits.
	function automatic bit hash_key(input logic [30:0] k, output int unsigned b);
		logic [63:0] sq, p;
		int n, stop;
		sq = 64'(k) * 64'(k);
		n = 1;
		p = 64'd10;
		while (n < 20 && sq >= p) begin
			n++;
			p = p * 64'd10;
		end
		b = 0;
		if (n < 7) return 0;
		stop = (n < 9) ? n : 9;
		p = 64'd1;
		for (int i = 0; i < n - stop; i++) p = p * 64'd10;
		sq = sq / p;
		p = 64'd1;
		for (int i = 0; i < stop - 6; i++) p = p * 64'd10;
		b = int'((sq % p) % mshash_pkg::BucketCount);
		return 1;
	endfunction

	function automatic table_result_t predict_lookup(input logic [63:0] d);
		table_result_t r;
		int unsigned b, f;
		logic [30:0] k;
		r = '0;
		r.status = mshash_pkg::ST_SHORT;
		k = d[31:1];
		if (hash_key(k, b)) begin
			f = fill_of[b];
			r.bucket = b[6:0];
			if (!d[0]) begin
				r.pos = f[3:0];
				if (f >= mshash_pkg::ChainDepth) r.status = mshash_pkg::ST_FULL;
				else begin
					key_of[b*mshash_pkg::ChainDepth+f] = k;
					pay_of[b*mshash_pkg::ChainDepth+f] = d[63:32];
					fill_of[b] = 4'(f + 1);
					r.status = mshash_pkg::ST_INSERTED;
				end
			end else begin
				r.status = mshash_pkg::ST_NOT_FOUND;
				r.probes = 4'(3 + f);
				for (int i = 0; i < f; i++)
					if (key_of[b*mshash_pkg::ChainDepth+i] == k) begin
						r.status = mshash_pkg::ST_FOUND;
						r.pos = 4'(i);
						r.payload = pay_of[b*mshash_pkg::ChainDepth+i];
						r.probes = 4'(3 + i);
						break;
					end
			end
		end
		return r;
	endfunction

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		table_result_t e, a;
		if (!arst_n) begin
			expected_results.delete();
			foreach (fill_of[i]) fill_of[i] = '0;
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_count <= result_count + 1;
				a = m_tdata[49:0];
				if (expected_results.size() == 0) begin
					$error("result with none expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (a != e || m_tdata[55:50] != 0) begin
						fail_count <= fail_count + 1;
						if (a.status != e.status)
							$error("status exp %0d got %0d", e.status, a.status);
						if (a.bucket != e.bucket)
							$error("bucket_index exp %0d got %0d", e.bucket, a.bucket);
						if (a.pos != e.pos)
							$error("chain_position exp %0d got %0d", e.pos, a.pos);
						if (a.payload != e.payload)
							$error("found_payload exp %h got %h", e.payload, a.payload);
						if (a.probes != e.probes)
							$error("probe_count exp %0d got %0d", e.probes, a.probes);
						if (m_tdata[55:50] != 0)
							$error("pad bits exp 0 got %h", m_tdata[55:50]);
					end
				end
			end
			if (s_tvalid && s_tready) expected_results.push_back(predict_lookup(s_tdata));
		end
	end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Top of the hash table testbench: clock, reset, insert/search item stimulus
// and the verdict. Depends on mshash_pkg, mshash_checker and the block.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0, arst_n = 0;
	logic        s_tvalid = 0, m_tready = 0;
	logic [63:0] s_tdata = '0;
	logic        s_tready, m_tvalid;
	logic [55:0] m_tdata;
	int          fail_count, pending_count, result_count;
	int          cycle_count = 0;
	bit          sink_calm = 0;
	logic [30:0] key_pool[$];

	mid_square_chained_hash_table u_dut (.*);
	mshash_checker u_chk (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("mid_square_chained_hash_table regression: fail");
			$finish;
		end
	end

	always @(posedge clk) m_tready <= sink_calm || ($urandom_range(99) >= 16);

	// Hold the item until it is taken; gaps only between items.
	task automatic send_item(input bit act, input logic [30:0] k, input logic [31:0] p,
			input bit calm);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {p, k, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [30:0] pick_key();
		case ($urandom_range(9))
			0: return 31'($urandom_range(999));
			1, 2: return 31'($urandom_range(1200, 31622));
			3: return 31'($urandom);
			4: return 31'h7FFFFFFF - 31'($urandom_range(3));
			default: return key_pool.size() ? key_pool[$urandom_range(key_pool.size()-1)]
				: 31'($urandom);
		endcase
	endfunction

	initial begin
		logic [30:0] k;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: short squares, extremes, duplicates, filling one bucket past full.
		send_item(0, 31'd0, 32'hFFFFFFFF, 0);
		send_item(1, 31'd0, 32'd0, 0);
		send_item(0, 31'd999, 32'h1, 0);
		send_item(0, 31'd1000, 32'hA5A5A5A5, 0);
		send_item(1, 31'd1000, 32'd0, 0);
		send_item(0, 31'h7FFFFFFF, 32'hFFFFFFFF, 0);
		send_item(1, 31'h7FFFFFFF, 32'hFFFFFFFF, 0);
		send_item(0, 31'd3162, 32'h5A5A5A5A, 0);
		send_item(0, 31'd31622, 32'h0, 0);
		send_item(1, 31'd31623, 32'h0, 0);
		for (int i = 0; i < 10; i++) send_item(0, 31'd12345, 32'(i) + 32'h100, 0);
		send_item(1, 31'd12345, 32'd0, 0);
		send_item(1, 31'd54321, 32'd0, 0);
		key_pool = '{31'd1000, 31'd12345, 31'h7FFFFFFF, 31'd3162, 31'd31622};
		// Pause until the block drains.
		s_tvalid <= 0;
		while (pending_count != 0) @(posedge clk);
		sink_calm = 1;
		for (int i = 0; i < 700; i++) begin
			if (i == 150) sink_calm = 0;
			k = pick_key();
			if ($urandom_range(1)) key_pool.push_back(k);
			send_item($urandom_range(1), k, $urandom, i < 150);
		end
		s_tvalid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Covered %0d results: short squares, full buckets, duplicates,", result_count);
		$display("hits and misses over random keys with stalls on both channels.");
		if (fail_count == 0)
			$display("mid_square_chained_hash_table regression: pass");
		else
			$display("mid_square_chained_hash_table regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
